@@ sv/pac_pkg.sv @@
// ----------------------------------------------------------------------------
// pac_pkg: shared types and constants of the proximity alarm controller
// Holds the mode and command codes, the register map and the state and
// configuration records that pass between the top level and the step logic.
// ----------------------------------------------------------------------------
package pac_pkg;

  // Default length of a test run in milliseconds.
  localparam int unsigned TEST_DURATION_MS_DEF = 3000;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned DIST_W  = 16;
  localparam int unsigned COLOR_W = 24;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned REG_W   = 3;

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_WATCH = 2'd1,
    MODE_ALARM = 2'd2,
    MODE_TEST  = 2'd3
  } pac_mode_t;

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_ON     = 2'd1,
    OP_OFF    = 2'd2,
    OP_TEST   = 2'd3
  } pac_op_t;

  // Register indexes, taken from byte address bits 4:2.
  localparam logic [REG_W-1:0] REG_TRIGGER  = 3'd0;
  localparam logic [REG_W-1:0] REG_BLINK    = 3'd1;
  localparam logic [REG_W-1:0] REG_TIMEOUT  = 3'd2;
  localparam logic [REG_W-1:0] REG_COLOUR_A = 3'd3;
  localparam logic [REG_W-1:0] REG_COLOUR_B = 3'd4;

  typedef struct packed {
    logic [DIST_W-1:0]  trigger;
    logic [TIME_W-1:0]  blink_period;
    logic [TIME_W-1:0]  clear_timeout;
    logic [COLOR_W-1:0] colour_a;
    logic [COLOR_W-1:0] colour_b;
  } pac_cfg_t;

  typedef struct packed {
    pac_mode_t          mode;
    logic               on_pend;
    logic               off_pend;
    logic [TIME_W-1:0]  last_detect;
    logic [TIME_W-1:0]  last_toggle;
    logic [TIME_W-1:0]  test_start;
    logic               phase;
    logic [COLOR_W-1:0] led;
    logic               buzzer;
  } pac_state_t;

  localparam pac_state_t STATE_RESET = '{
    mode:        MODE_OFF,
    on_pend:     1'b0,
    off_pend:    1'b0,
    last_detect: '0,
    last_toggle: '0,
    test_start:  '0,
    phase:       1'b0,
    led:         '0,
    buzzer:      1'b0
  };

endpackage

@@ sv/pac_step.sv @@
// ----------------------------------------------------------------------------
// pac_step: next-state logic for one word
// Applies one command to the controller state: samples run the mode machine,
// turn on and turn off only set their pending flags, test starts a test run.
// ----------------------------------------------------------------------------
module pac_step #(
  parameter int unsigned TEST_DURATION_MS = pac_pkg::TEST_DURATION_MS_DEF
) (
  input  pac_pkg::pac_state_t               state_i,
  input  pac_pkg::pac_cfg_t                 cfg_i,
  input  pac_pkg::pac_op_t                  op_i,
  input  logic [pac_pkg::TIME_W-1:0]        now_i,
  input  logic [pac_pkg::DIST_W-1:0]        dist_i,
  output pac_pkg::pac_state_t               state_o
);
  import pac_pkg::*;

  logic              near;
  logic [TIME_W-1:0] since_toggle;
  logic [TIME_W-1:0] since_detect;
  logic [TIME_W-1:0] since_test;
  pac_state_t        pre;

  assign near         = (dist_i <= cfg_i.trigger);
  assign since_toggle = now_i - state_i.last_toggle;
  assign since_test   = now_i - state_i.test_start;
  // The detect time may just have been refreshed by a pending turn-on.
  assign since_detect = now_i - pre.last_detect;

  // Pending commands take effect first, turn-off winning over turn-on.
  always_comb begin
    pre = state_i;
    if (state_i.on_pend) begin
      pre.mode        = MODE_ALARM;
      pre.on_pend     = 1'b0;
      pre.last_detect = now_i;
    end
    if (state_i.off_pend) begin
      pre.mode     = MODE_OFF;
      pre.off_pend = 1'b0;
      pre.led      = '0;
      pre.buzzer   = 1'b0;
    end
  end

  always_comb begin
    state_o = state_i;
    unique case (op_i)
      OP_ON:  state_o.on_pend  = 1'b1;
      OP_OFF: state_o.off_pend = 1'b1;
      OP_TEST: begin
        state_o.mode       = MODE_TEST;
        state_o.test_start = now_i;
      end
      OP_SAMPLE: begin
        state_o = pre;
        unique case (pre.mode)
          MODE_OFF: begin
            state_o.led    = '0;
            state_o.buzzer = 1'b0;
            if (near) begin
              state_o.mode        = MODE_ALARM;
              state_o.last_detect = now_i;
            end else begin
              state_o.mode = MODE_WATCH;
            end
          end
          MODE_WATCH: begin
            if (near) begin
              state_o.mode        = MODE_ALARM;
              state_o.last_detect = now_i;
            end
          end
          MODE_ALARM: begin
            if (since_toggle >= cfg_i.blink_period) begin
              state_o.phase       = ~pre.phase;
              state_o.led         = pre.phase ? cfg_i.colour_b : cfg_i.colour_a;
              state_o.last_toggle = now_i;
            end
            state_o.buzzer = 1'b1;
            if (near) begin
              state_o.last_detect = now_i;
            end else if (since_detect >= cfg_i.clear_timeout) begin
              state_o.mode   = MODE_WATCH;
              state_o.led    = '0;
              state_o.buzzer = 1'b0;
            end
          end
          MODE_TEST: begin
            state_o.led    = cfg_i.colour_a;
            state_o.buzzer = 1'b1;
            if (since_test >= TIME_W'(TEST_DURATION_MS)) begin
              state_o.mode   = MODE_OFF;
              state_o.led    = '0;
              state_o.buzzer = 1'b0;
            end
          end
        endcase
      end
    endcase
  end

endmodule

@@ sv/proximity_alarm_controller.sv @@
// ----------------------------------------------------------------------------
// proximity_alarm_controller: proximity alarm with off, watch, alarm and test
// Top level: input register, step logic, result register and register file.
// ----------------------------------------------------------------------------
// The controller takes one word per clock cycle while in_stall is low and
// returns exactly one result word for each. A word is first captured in the
// input register; once the result register is free or being taken, the
// step logic applies it to the controller state and the new LED levels,
// buzzer and mode are loaded into the result register, which presents the
// result. The state registers and the result register are written on the
// same edge, so back to back words see each other's effect with no
// bubbles. The input register keeps taking words while a finished result
// waits for the receiver; only when both stages are full and the output is
// stalled does in_stall rise.
// Configuration is an APB-style 32-bit port with five registers at byte
// addresses 0x00 (trigger distance), 0x04 (blink period), 0x08 (clear
// timeout), 0x0C (colour A) and 0x10 (colour B); writes to the unused
// addresses are ignored and read back as zero. The registers should only be
// written while no word is in flight. Time differences wrap modulo 2^32.
module proximity_alarm_controller #(
  parameter int unsigned TEST_DURATION_MS = pac_pkg::TEST_DURATION_MS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [pac_pkg::TIME_W-1:0]    in_now_ms,
  input  logic [pac_pkg::DIST_W-1:0]    in_distance_mm,
  // Result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    out_red_level,
  output logic [7:0]                    out_green_level,
  output logic [7:0]                    out_blue_level,
  output logic                          out_buzzer_on,
  output logic [1:0]                    out_mode,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pac_pkg::ADDR_W-1:0]    paddr,
  input  logic [pac_pkg::DATA_W-1:0]    pwdata,
  output logic [pac_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import pac_pkg::*;

  // Configuration registers.
  pac_cfg_t          cfg_r;
  logic [REG_W-1:0]  reg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TRIGGER:  cfg_r.trigger       <= pwdata[DIST_W-1:0];
        REG_BLINK:    cfg_r.blink_period  <= pwdata[TIME_W-1:0];
        REG_TIMEOUT:  cfg_r.clear_timeout <= pwdata[TIME_W-1:0];
        REG_COLOUR_A: cfg_r.colour_a      <= pwdata[COLOR_W-1:0];
        REG_COLOUR_B: cfg_r.colour_b      <= pwdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_TRIGGER:  prdata = DATA_W'(cfg_r.trigger);
      REG_BLINK:    prdata = DATA_W'(cfg_r.blink_period);
      REG_TIMEOUT:  prdata = DATA_W'(cfg_r.clear_timeout);
      REG_COLOUR_A: prdata = DATA_W'(cfg_r.colour_a);
      REG_COLOUR_B: prdata = DATA_W'(cfg_r.colour_b);
      default:      prdata = '0;
    endcase
  end

  // Input register stage.
  logic              s1_valid_r;
  pac_op_t           s1_op_r;
  logic [TIME_W-1:0] s1_now_r;
  logic [DIST_W-1:0] s1_dist_r;
  logic              s1_adv;
  logic              in_take;

  // Result register stage.
  logic              out_valid_r;
  logic [COLOR_W-1:0] out_led_r;
  logic              out_buzzer_r;
  pac_mode_t         out_mode_r;

  // Controller state.
  pac_state_t        state_r;
  pac_state_t        state_nxt;

  // The stage moves on whenever the result register is free or being taken.
  assign s1_adv   = s1_valid_r & ~(out_valid_r & out_stall);
  assign in_stall = s1_valid_r & out_valid_r & out_stall;
  assign in_take  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r   <= pac_op_t'(in_operation);
      s1_now_r  <= in_now_ms;
      s1_dist_r <= in_distance_mm;
    end
  end

  pac_step #(
    .TEST_DURATION_MS (TEST_DURATION_MS)
  ) u_step (
    .state_i (state_r),
    .cfg_i   (cfg_r),
    .op_i    (s1_op_r),
    .now_i   (s1_now_r),
    .dist_i  (s1_dist_r),
    .state_o (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (~out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_led_r    <= state_nxt.led;
      out_buzzer_r <= state_nxt.buzzer;
      out_mode_r   <= state_nxt.mode;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red_level   = out_led_r[23:16];
  assign out_green_level = out_led_r[15:8];
  assign out_blue_level  = out_led_r[7:0];
  assign out_buzzer_on   = out_buzzer_r;
  assign out_mode        = out_mode_r;

  // The input side only stalls while a word sits in the input register.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with the input register empty");

  // A word leaving the input register always yields a result.
  a_adv_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("word processed without a result");

  // A processed sample always consumes both pending commands.
  a_sample_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_op_r == OP_SAMPLE) |=> (!state_r.on_pend && !state_r.off_pend))
    else $error("pending command survived a sample");

  // Off and watching never drive the LEDs or the buzzer.
  a_quiet_modes_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_OFF || state_r.mode == MODE_WATCH)
      |-> (state_r.led == '0 && !state_r.buzzer))
    else $error("LEDs or buzzer active while off or watching");

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the proximity alarm controller
// Drives command and sample words with random gaps and receiver stalls,
// mirrors the alarm state in a scoreboard class and checks every result word
// field by field against the mirrored LED levels, buzzer and mode.
// ----------------------------------------------------------------------------
module tb;
  import pac_pkg::*;

  // Result word as the controller reports it.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       buzzer;
    logic [1:0] mode;
  } indication_t;

  // The mirror keeps its own copy of the registers and of the alarm state,
  // and queues the result word that each accepted input word must produce.
  class alarm_mirror;
    logic [DIST_W-1:0]  trigger;
    logic [TIME_W-1:0]  blink;
    logic [TIME_W-1:0]  timeout;
    logic [COLOR_W-1:0] col_a;
    logic [COLOR_W-1:0] col_b;
    pac_mode_t          mode;
    logic               on_pend;
    logic               off_pend;
    logic [TIME_W-1:0]  last_detect;
    logic [TIME_W-1:0]  last_toggle;
    logic [TIME_W-1:0]  test_start;
    logic               phase;
    logic [COLOR_W-1:0] led;
    logic               buzzer;
    indication_t        due_words[$];
    int unsigned        mismatches;

    function new();
      trigger     = '0;
      blink       = '0;
      timeout     = '0;
      col_a       = '0;
      col_b       = '0;
      mode        = MODE_OFF;
      on_pend     = 1'b0;
      off_pend    = 1'b0;
      last_detect = '0;
      last_toggle = '0;
      test_start  = '0;
      phase       = 1'b0;
      led         = '0;
      buzzer      = 1'b0;
      mismatches  = 0;
    endfunction

    // Writes to unused indexes fall through and change nothing.
    function void set_register(logic [REG_W-1:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_TRIGGER:  trigger = value[DIST_W-1:0];
        REG_BLINK:    blink   = value;
        REG_TIMEOUT:  timeout = value;
        REG_COLOUR_A: col_a   = value[COLOR_W-1:0];
        REG_COLOUR_B: col_b   = value[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_word(pac_op_t op, logic [TIME_W-1:0] now, logic [DIST_W-1:0] dist_mm);
      logic              near;
      logic [TIME_W-1:0] since_toggle;
      logic [TIME_W-1:0] since_detect;
      logic [TIME_W-1:0] since_test;
      indication_t       res;
      near         = (dist_mm <= trigger);
      since_toggle = now - last_toggle;
      since_detect = now - last_detect;
      since_test   = now - test_start;
      case (op)
        OP_SAMPLE: begin
          // Pending turn-on is applied before pending turn-off.
          if (on_pend) begin
            mode        = MODE_ALARM;
            on_pend     = 1'b0;
            last_detect = now;
            since_detect = '0;
          end
          if (off_pend) begin
            mode     = MODE_OFF;
            off_pend = 1'b0;
            led      = '0;
            buzzer   = 1'b0;
          end
          case (mode)
            MODE_OFF: begin
              led    = '0;
              buzzer = 1'b0;
              if (near) begin
                mode        = MODE_ALARM;
                last_detect = now;
              end else begin
                mode = MODE_WATCH;
              end
            end
            MODE_WATCH: begin
              if (near) begin
                mode        = MODE_ALARM;
                last_detect = now;
              end
            end
            MODE_ALARM: begin
              if (since_toggle >= blink) begin
                phase       = !phase;
                led         = phase ? col_a : col_b;
                last_toggle = now;
              end
              buzzer = 1'b1;
              if (!near) begin
                if (since_detect >= timeout) begin
                  mode   = MODE_WATCH;
                  led    = '0;
                  buzzer = 1'b0;
                end
              end else begin
                last_detect = now;
              end
            end
            default: begin
              led    = col_a;
              buzzer = 1'b1;
              if (since_test >= TEST_DURATION_MS_DEF) begin
                mode   = MODE_OFF;
                led    = '0;
                buzzer = 1'b0;
              end
            end
          endcase
        end
        OP_ON:  on_pend  = 1'b1;
        OP_OFF: off_pend = 1'b1;
        default: begin
          mode       = MODE_TEST;
          test_start = now;
        end
      endcase
      res.red    = led[23:16];
      res.green  = led[15:8];
      res.blue   = led[7:0];
      res.buzzer = buzzer;
      res.mode   = mode;
      due_words.push_back(res);
    endfunction

    function void check_word(indication_t got);
      indication_t want;
      if (due_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: rgb %02h%02h%02h buzzer %0b mode %0d",
                   got.red, got.green, got.blue, got.buzzer, got.mode);
        return;
      end
      want = due_words.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.buzzer !== want.buzzer || got.mode !== want.mode) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected rgb %02h%02h%02h buzzer %0b mode %0d, got rgb %02h%02h%02h buzzer %0b mode %0d",
                   want.red, want.green, want.blue, want.buzzer, want.mode,
                   got.red, got.green, got.blue, got.buzzer, got.mode);
      end
    endfunction

    function int unsigned waiting();
      return due_words.size();
    endfunction
  endclass

  localparam int unsigned WORDS_PER_PHASE = 100;
  localparam int unsigned LONG_HOLD       = 40;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           in_operation;
  logic [TIME_W-1:0]    in_now_ms;
  logic [DIST_W-1:0]    in_distance_mm;
  logic                 out_valid;
  logic                 out_stall;
  logic [7:0]           out_red_level;
  logic [7:0]           out_green_level;
  logic [7:0]           out_blue_level;
  logic                 out_buzzer_on;
  logic [1:0]           out_mode;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_W-1:0]    paddr;
  logic [DATA_W-1:0]    pwdata;
  logic [DATA_W-1:0]    prdata;
  logic                 pready;

  alarm_mirror          mirror;
  logic [TIME_W-1:0]    clock_ms;
  // gaps_on lets both sides idle at random; hold_request asks the receiver
  // for one long stall while the sender keeps offering words.
  bit                   gaps_on;
  bit                   hold_request;

  proximity_alarm_controller u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_now_ms       (in_now_ms),
    .in_distance_mm  (in_distance_mm),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red_level   (out_red_level),
    .out_green_level (out_green_level),
    .out_blue_level  (out_blue_level),
    .out_buzzer_on   (out_buzzer_on),
    .out_mode        (out_mode),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Both handshakes are sampled at the rising edge, where every signal still
  // holds the value it had before the edge. The input word is noted before
  // the result is checked, so the order would also be right for a block
  // that returned its result combinationally.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        mirror.take_word(pac_op_t'(in_operation), in_now_ms, in_distance_mm);
      if (out_valid && !out_stall)
        mirror.check_word('{out_red_level, out_green_level, out_blue_level,
                            out_buzzer_on, out_mode});
    end
  end

  // Receiver: short random stall bursts while gaps are allowed, and one long
  // hold-off counted here in cycles when the sequencer asks for it.
  initial begin
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one word and return at the edge at which it is taken. Valid stays
  // high on return, so a following word simply replaces the payload.
  task automatic send_word(pac_op_t op, logic [TIME_W-1:0] now, logic [DIST_W-1:0] dist_mm);
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_now_ms      <= now;
    in_distance_mm <= dist_mm;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop offering words and wait for every outstanding result. The count is
  // looked at on the falling edge, when the monitor has settled.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (mirror.waiting() != 0);
    @(posedge clk);
  endtask

  // Setup cycle, then the access cycle; psel is left high so that writes can
  // follow one another, and the caller lowers it after the last one.
  task automatic write_reg(logic [REG_W-1:0] idx, logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    mirror.set_register(idx, value);
  endtask

  // Every word yields a result, so once the queue is empty the block is idle;
  // a short pause covers the two-stage pipeline all the same. Upper bits of
  // narrow registers are passed through unmasked, and one write to an unused
  // address checks that it is ignored.
  task automatic configure(logic [DATA_W-1:0] trig, logic [DATA_W-1:0] blink,
                           logic [DATA_W-1:0] timeout, logic [DATA_W-1:0] ca,
                           logic [DATA_W-1:0] cb);
    drain();
    repeat (4) @(posedge clk);
    write_reg(REG_TRIGGER, trig);
    write_reg(REG_BLINK, blink);
    write_reg(REG_TIMEOUT, timeout);
    write_reg(REG_COLOUR_A, ca);
    write_reg(REG_COLOUR_B, cb);
    write_reg(REG_W'($urandom_range(REG_COLOUR_B + 1, (1 << REG_W) - 1)), $urandom());
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One random phase: a register setting, then words whose distances come in
  // runs of near and clear readings and whose time stamps advance by small
  // steps, by exact test-length fractions, or by arbitrary jumps that wrap.
  task automatic random_phase(int unsigned phase_no);
    pac_op_t           op;
    logic [DIST_W-1:0] dist_mm;
    logic [DIST_W-1:0] trig;
    logic [TIME_W-1:0] step;
    bit                close_run;
    case (phase_no)
      0: configure(32'd300, 32'd25, 32'd120, $urandom(), $urandom());
      1: configure($urandom() & 32'hFFFF_0000, 32'd0, 32'd0, $urandom(), $urandom());
      2: configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
      3: configure($urandom_range(1, 5000), $urandom_range(1, 60), $urandom_range(0, 300),
                   $urandom(), $urandom());
      4: configure($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
      default: configure($urandom_range(100, 3000), $urandom_range(0, 200),
                         $urandom_range(0, 500), $urandom(), $urandom());
    endcase
    // Phases two and five run with no idling; the last one closes the run.
    gaps_on   = (phase_no != 2) && (phase_no != 5);
    trig      = mirror.trigger;
    clock_ms  = (phase_no == 1) ? 32'hFFFF_FF00 : $urandom();
    close_run = 1'b0;
    for (int unsigned n = 0; n < WORDS_PER_PHASE; n++) begin
      if (phase_no == 0 && n == 5)
        hold_request = 1'b1;
      if (phase_no == 1 && n == WORDS_PER_PHASE / 2)
        drain();
      case ($urandom_range(0, 15))
        0:       op = OP_ON;
        1:       op = OP_OFF;
        2:       op = OP_TEST;
        3:       op = $urandom_range(0, 1) ? OP_ON : OP_OFF;
        default: op = OP_SAMPLE;
      endcase
      case ($urandom_range(0, 9))
        0:       step = '0;
        1:       step = 32'd500;
        2:       step = 32'd1000;
        3:       step = $urandom_range(0, 4000);
        4:       step = $urandom();
        default: step = $urandom_range(0, 40);
      endcase
      if ($urandom_range(0, 7) == 0)
        close_run = !close_run;
      case ($urandom_range(0, 9))
        0:       dist_mm = trig;
        1:       dist_mm = trig + 16'd1;
        2:       dist_mm = DIST_W'($urandom());
        default: dist_mm = close_run ? DIST_W'($urandom_range(0, trig))
                                     : DIST_W'($urandom_range(trig, 16'hFFFF));
      endcase
      clock_ms = clock_ms + step;
      send_word(op, clock_ms, dist_mm);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end
    end
  endtask

  initial begin
    #4_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    mirror         = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_operation   = OP_SAMPLE;
    in_now_ms      = '0;
    in_distance_mm = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    gaps_on        = 1'b1;
    hold_request   = 1'b0;
    clock_ms       = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words. Zero blink period and zero timeout first, with time
    // stamps that wrap past the top of the 32-bit range during the test run.
    configure({16'hA5A5, 16'd500}, 32'd0, 32'd0, 32'h00FF_8001, 32'h5A01_7FFE);
    clock_ms = 32'hFFFF_FA00;
    send_word(OP_SAMPLE, clock_ms,         16'hFFFF);  // off, far: goes watching
    send_word(OP_SAMPLE, clock_ms + 32'd1, 16'd500);   // exactly at trigger: alarm
    send_word(OP_SAMPLE, clock_ms + 32'd1, 16'd500);   // zero period flips the colour
    send_word(OP_SAMPLE, clock_ms + 32'd2, 16'd501);   // zero timeout: first clear word leaves
    send_word(OP_ON,     clock_ms + 32'd3, 16'hFFFF);
    send_word(OP_SAMPLE, clock_ms + 32'd4, 16'hFFFF);  // pending turn-on, then clear
    send_word(OP_ON,     clock_ms + 32'd5, 16'd0);
    send_word(OP_OFF,    clock_ms + 32'd5, 16'd0);
    send_word(OP_SAMPLE, clock_ms + 32'd6, 16'd0);     // both pending: turn-off wins
    send_word(OP_TEST,   clock_ms + 32'd10, 16'd0);
    send_word(OP_SAMPLE, clock_ms + 32'd3009, 16'hFFFF); // one short of the test length
    send_word(OP_SAMPLE, clock_ms + 32'd3010, 16'hFFFF); // test ends after the wrap
    send_word(OP_TEST,   clock_ms + 32'd3100, 16'd0);
    send_word(OP_ON,     clock_ms + 32'd3101, 16'd0);
    send_word(OP_SAMPLE, clock_ms + 32'd3102, 16'd7);  // pending turn-on cuts the test short
    send_word(OP_OFF,    clock_ms + 32'd3103, 16'd0);
    send_word(OP_TEST,   clock_ms + 32'd3104, 16'd0);
    send_word(OP_SAMPLE, clock_ms + 32'd3105, 16'd0);  // pending turn-off cuts the test short

    // Widest settings: every distance is near, the colour never changes.
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_word(OP_SAMPLE, 32'h0000_0000, 16'hFFFF);
    send_word(OP_SAMPLE, 32'h8000_0000, 16'hFFFF);
    send_word(OP_SAMPLE, 32'hFFFF_FFFF, 16'h8000);
    // Narrowest trigger: only a distance of zero is near.
    configure(32'h0, 32'd1, 32'd1, 32'h0012_3456, 32'h00FE_DCBA);
    send_word(OP_SAMPLE, 32'h0000_0010, 16'd1);
    send_word(OP_SAMPLE, 32'h0000_0011, 16'd0);
    send_word(OP_SAMPLE, 32'h0000_0012, 16'd1);
    send_word(OP_SAMPLE, 32'h0000_0013, 16'd1);

    for (int unsigned p = 0; p < 6; p++)
      random_phase(p);

    drain();
    repeat (10) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.waiting() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
